>>> rtl/cf3p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cf3p_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_COLL = 2'd1,
    ST_SING = 2'd2,
    ST_OVF  = 2'd3
  } cf3p_status_t;

  // result word width
  localparam int OUT_W = 48;

  // rough bit-product budget for one multiplier stage
  localparam int MUL_AREA = 1024;

  // saturation bounds of the result words
  localparam logic signed [63:0] CEN_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] CEN_MIN = -64'sd140737488355328;
  localparam logic [63:0]        RAD_MAX = 64'd281474976710655;

endpackage

`default_nettype wire

>>> rtl/cf3p_if.sv
`timescale 1ns / 1ps
`default_nettype none

// point triple channel
interface cf3p_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] px_a;
  logic signed [COORD_WIDTH-1:0] py_a;
  logic signed [COORD_WIDTH-1:0] px_b;
  logic signed [COORD_WIDTH-1:0] py_b;
  logic signed [COORD_WIDTH-1:0] px_c;
  logic signed [COORD_WIDTH-1:0] py_c;

  modport source (output valid, px_a, py_a, px_b, py_b, px_c, py_c, input ready);
  modport sink   (input valid, px_a, py_a, px_b, py_b, px_c, py_c, output ready);
endinterface

// circle result channel
interface cf3p_out_if;
  import cf3p_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] center_x;
  logic signed [OUT_W-1:0] center_y;
  logic [OUT_W-1:0]        radius_out;
  cf3p_status_t            fit_status;

  modport source (output valid, center_x, center_y, radius_out, fit_status, input ready);
  modport sink   (input valid, center_x, center_y, radius_out, fit_status, output ready);
endinterface

`default_nettype wire

>>> rtl/cf3p_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// pipelined signed multiplier lanes, one digit of b per stage
module cf3p_mul #(
  parameter int LANES = 1,
  parameter int WA    = 8,
  parameter int WB    = 8,
  parameter int DG    = 8,
  parameter int WS    = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [WA-1:0]    in_a [LANES],
  input  logic signed [WB-1:0]    in_b [LANES],
  input  logic [WS-1:0]           in_side,
  output logic                    out_vld,
  output logic signed [WA+WB-1:0] out_p [LANES],
  output logic [WS-1:0]           out_side
);

  localparam int ND = (WB + DG - 1) / DG;
  localparam int BW = ND * DG;
  localparam int PW = WA + WB;

  logic signed [WA-1:0] a_r   [ND][LANES];
  logic signed [WB-1:0] b_r   [ND][LANES];
  logic signed [PW-1:0] acc_r [ND][LANES];
  logic [WS-1:0]        side_r [ND];
  logic                 vld_r  [ND];

  for (genvar k = 0; k < ND; k++) begin : g_stg
    logic signed [WA-1:0] a_in    [LANES];
    logic signed [WB-1:0] b_in    [LANES];
    logic signed [PW-1:0] acc_in  [LANES];
    logic signed [PW-1:0] acc_nxt [LANES];
    logic [WS-1:0]        side_in;
    logic                 vld_in;

    // stage source
    if (k == 0) begin : g_first
      assign a_in    = in_a;
      assign b_in    = in_b;
      assign side_in = in_side;
      assign vld_in  = in_vld;
      always_comb begin
        for (int l = 0; l < LANES; l++) acc_in[l] = '0;
      end
    end else begin : g_next
      assign a_in    = a_r[k-1];
      assign b_in    = b_r[k-1];
      assign acc_in  = acc_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    // partial product of this digit, added at its weight
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [BW-1:0]         b_ext;
      logic [DG-1:0]         dig_u;
      logic signed [DG:0]    dig;
      logic signed [WA+DG:0] pp;

      assign b_ext = BW'(b_in[l]);
      assign dig_u = b_ext[k*DG +: DG];
      if (k == ND - 1) begin : g_top
        assign dig = {dig_u[DG-1], dig_u};
      end else begin : g_low
        assign dig = {1'b0, dig_u};
      end
      assign pp         = a_in[l] * dig;
      assign acc_nxt[l] = acc_in[l] + (PW'(pp) <<< (k * DG));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k]  <= acc_nxt;
        side_r[k] <= side_in;
      end
    end

    // operands travel on while digits remain
    if (k < ND - 1) begin : g_opnd
      always_ff @(posedge clk) begin
        if (en) begin
          a_r[k] <= a_in;
          b_r[k] <= b_in;
        end
      end
    end
  end

  assign out_vld  = vld_r[ND-1];
  assign out_p    = acc_r[ND-1];
  assign out_side = side_r[ND-1];

endmodule

`default_nettype wire

>>> rtl/cf3p_div.sv
`timescale 1ns / 1ps
`default_nettype none

// pipelined unsigned restoring divider lanes, one quotient bit per stage
module cf3p_div #(
  parameter int LANES = 1,
  parameter int NW    = 8,
  parameter int DW    = 8,
  parameter int WS    = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_n [LANES],
  input  logic [DW-1:0] in_d [LANES],
  input  logic [WS-1:0] in_side,
  output logic          out_vld,
  output logic [NW-1:0] out_q [LANES],
  output logic [WS-1:0] out_side
);

  logic [NW-1:0] n_r    [NW][LANES];
  logic [DW-1:0] d_r    [NW][LANES];
  logic [DW-1:0] rem_r  [NW][LANES];
  logic [NW-1:0] q_r    [NW][LANES];
  logic [WS-1:0] side_r [NW];
  logic          vld_r  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stg
    logic [NW-1:0] n_in    [LANES];
    logic [DW-1:0] d_in    [LANES];
    logic [DW-1:0] rem_in  [LANES];
    logic [NW-1:0] q_in    [LANES];
    logic [DW-1:0] rem_nxt [LANES];
    logic [NW-1:0] q_nxt   [LANES];
    logic [WS-1:0] side_in;
    logic          vld_in;

    if (k == 0) begin : g_first
      assign n_in    = in_n;
      assign d_in    = in_d;
      assign side_in = in_side;
      assign vld_in  = in_vld;
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = '0;
          q_in[l]   = '0;
        end
      end
    end else begin : g_next
      assign n_in    = n_r[k-1];
      assign d_in    = d_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    // bring down one numerator bit, trial subtract
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW:0] rem_sh;
      logic [DW:0] diff;
      logic        ge;

      assign rem_sh     = {rem_in[l], n_in[l][NW-1-k]};
      assign diff       = rem_sh - {1'b0, d_in[l]};
      assign ge         = rem_sh >= {1'b0, d_in[l]};
      assign rem_nxt[l] = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      assign q_nxt[l]   = {q_in[l][NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        q_r[k]    <= q_nxt;
        side_r[k] <= side_in;
      end
    end

    if (k < NW - 1) begin : g_opnd
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[k] <= n_in;
          d_r[k] <= d_in;
        end
      end
    end
  end

  assign out_vld  = vld_r[NW-1];
  assign out_q    = q_r[NW-1];
  assign out_side = side_r[NW-1];

endmodule

`default_nettype wire

>>> rtl/cf3p_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// pipelined integer square root, one root bit per stage
module cf3p_sqrt #(
  parameter int SW = 16,
  parameter int WS = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [SW-1:0]   in_v,
  input  logic [WS-1:0]   in_side,
  output logic            out_vld,
  output logic [SW/2-1:0] out_root,
  output logic [WS-1:0]   out_side
);

  localparam int RW = SW / 2;

  logic [SW-1:0]   v_r    [RW];
  logic [RW-1:0]   root_r [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [WS-1:0]   side_r [RW];
  logic            vld_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    logic [SW-1:0] v_in;
    logic [RW-1:0] root_in;
    logic [RW+1:0] rem_in;
    logic [WS-1:0] side_in;
    logic          vld_in;
    logic [RW+3:0] rem_sh;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = in_v;
      assign root_in = '0;
      assign rem_in  = '0;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    // next bit pair against 4*root+1
    assign rem_sh = {rem_in, v_in[SW-1-2*k -: 2]};
    assign trial  = (RW+4)'({root_in, 2'b01});
    assign diff   = rem_sh - trial;
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
        root_r[k] <= {root_in[RW-2:0], ge};
        side_r[k] <= side_in;
      end
    end

    if (k < RW - 1) begin : g_opnd
      always_ff @(posedge clk) begin
        if (en) begin
          v_r[k] <= v_in;
        end
      end
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_side = side_r[RW-1];

endmodule

`default_nettype wire

>>> rtl/circle_from_three_points.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | contents
// ---------+-----+------------------------------------------------------
// in_bus   | in  | px_a py_a px_b py_b px_c py_c, signed Q.16 coordinates
// out_bus  | out | center_x center_y (Q31.16), radius_out (Q32.16), status
//
// one triple per cycle while the output is not stalled; the pipeline holds the
// stage registers, the multiplier digit stages, one stage per root bit and one
// stage per quotient bit
// synchronous active-low reset clears only the valid bits
// a stalled result freezes the whole pipeline, so nothing is lost or repeated
module circle_from_three_points #(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  cf3p_in_if.sink   in_bus,
  cf3p_out_if.source out_bus
);
  import cf3p_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DFW  = W + 1;       // point differences
  localparam int P1W  = 2 * DFW;     // first products
  localparam int DTW  = 2 * W + 3;   // det, |b|^2, |c|^2
  localparam int DDW  = 2 * W + 4;   // 2*det
  localparam int NXW  = 3 * W + 4;   // center numerators
  localparam int SQW  = 6 * W + 6;   // nx^2 + ny^2
  localparam int RTW  = SQW / 2;     // its root
  localparam int NMW  = 3 * W + 5;   // divider numerator
  localparam int DVW  = 2 * W + 4;   // divider divisor
  localparam int CSW  = NMW + 2;     // center sum

  localparam int M1_DG = (MUL_AREA / DFW < DFW) ? MUL_AREA / DFW : DFW;
  localparam int M2_DG = (MUL_AREA / DFW < DTW) ? MUL_AREA / DFW : DTW;
  localparam int M3_DG = (MUL_AREA / NXW < NXW) ? MUL_AREA / NXW : NXW;

  typedef struct packed {
    logic ydiff;   // both y steps nonzero
    logic alleq;   // all x or all y equal
  } fl_t;

  typedef struct packed {
    logic signed [W-1:0]   x1;
    logic signed [W-1:0]   y1;
    fl_t                   fl;
    logic signed [DFW-1:0] bx;
    logic signed [DFW-1:0] by;
    logic signed [DFW-1:0] cx;
    logic signed [DFW-1:0] cy;
  } s1_t;

  typedef struct packed {
    logic signed [W-1:0]   x1;
    logic signed [W-1:0]   y1;
    cf3p_status_t          code;
    logic signed [DDW-1:0] d;
  } s2_t;

  typedef struct packed {
    s2_t                   base;
    logic signed [NXW-1:0] nx;
    logic signed [NXW-1:0] ny;
  } s3_t;

  typedef struct packed {
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    cf3p_status_t        code;
    logic                negx;
    logic                negy;
  } s4_t;

  logic en;

  // global advance: output register free or being drained
  assign en           = !out_bus.valid || out_bus.ready;
  assign in_bus.ready = en;

  // stage a: differences and equality flags
  logic                  va_r;
  logic signed [W-1:0]   x1_r, y1_r;
  logic signed [DFW-1:0] dbx_r, dby_r, dcx_r, dcy_r;
  fl_t                   fla_r;
  logic signed [W-1:0]   p1x, p1y, p2x, p2y, p3x, p3y;

  assign p1x = in_bus.px_a;
  assign p1y = in_bus.py_a;
  assign p2x = in_bus.px_b;
  assign p2y = in_bus.py_b;
  assign p3x = in_bus.px_c;
  assign p3y = in_bus.py_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r        <= p1x;
      y1_r        <= p1y;
      dbx_r       <= DFW'(p2x) - DFW'(p1x);
      dby_r       <= DFW'(p2y) - DFW'(p1y);
      dcx_r       <= DFW'(p3x) - DFW'(p1x);
      dcy_r       <= DFW'(p3y) - DFW'(p1y);
      fla_r.ydiff <= (p1y != p2y) && (p2y != p3y);
      fla_r.alleq <= ((p1x == p2x) && (p2x == p3x)) || ((p1y == p2y) && (p2y == p3y));
    end
  end

  // first products: cross terms and squares
  logic signed [DFW-1:0] m1_a [6];
  logic signed [DFW-1:0] m1_b [6];
  logic signed [P1W-1:0] m1_p [6];
  s1_t                   m1_si, m1_so;
  logic                  m1_vld;

  assign m1_a = '{dbx_r, dby_r, dbx_r, dby_r, dcx_r, dcy_r};
  assign m1_b = '{dcy_r, dcx_r, dbx_r, dby_r, dcx_r, dcy_r};
  assign m1_si = '{x1: x1_r, y1: y1_r, fl: fla_r, bx: dbx_r, by: dby_r, cx: dcx_r, cy: dcy_r};

  cf3p_mul #(.LANES(6), .WA(DFW), .WB(DFW), .DG(M1_DG), .WS($bits(s1_t))) u_mul1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (va_r),
    .in_a     (m1_a),
    .in_b     (m1_b),
    .in_side  (m1_si),
    .out_vld  (m1_vld),
    .out_p    (m1_p),
    .out_side (m1_so)
  );

  // stage b: determinant, squared lengths, status
  logic signed [DTW-1:0] det;
  logic                  det0;
  logic                  coll;
  cf3p_status_t          code_nxt;

  assign det  = DTW'(m1_p[0]) - DTW'(m1_p[1]);
  assign det0 = det == '0;
  assign coll = (m1_so.fl.ydiff && det0) || m1_so.fl.alleq;

  always_comb begin
    if (coll) begin
      code_nxt = ST_COLL;
    end else if (det0) begin
      code_nxt = ST_SING;
    end else begin
      code_nxt = ST_OK;
    end
  end

  logic                  vb_r;
  s2_t                   sb_r;
  logic signed [DFW-1:0] bx_b_r, by_b_r, cx_b_r, cy_b_r;
  logic signed [DTW-1:0] bb_r, cc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r.x1   <= m1_so.x1;
      sb_r.y1   <= m1_so.y1;
      sb_r.code <= code_nxt;
      sb_r.d    <= DDW'(det) <<< 1;
      bx_b_r    <= m1_so.bx;
      by_b_r    <= m1_so.by;
      cx_b_r    <= m1_so.cx;
      cy_b_r    <= m1_so.cy;
      bb_r      <= DTW'(m1_p[2]) + DTW'(m1_p[3]);
      cc_r      <= DTW'(m1_p[4]) + DTW'(m1_p[5]);
    end
  end

  // second products: center numerator terms
  logic signed [DFW-1:0] m2_a [4];
  logic signed [DTW-1:0] m2_b [4];
  logic signed [NXW-1:0] m2_p [4];
  s2_t                   m2_so;
  logic                  m2_vld;

  assign m2_a = '{cy_b_r, by_b_r, bx_b_r, cx_b_r};
  assign m2_b = '{bb_r, cc_r, cc_r, bb_r};

  cf3p_mul #(.LANES(4), .WA(DFW), .WB(DTW), .DG(M2_DG), .WS($bits(s2_t))) u_mul2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vb_r),
    .in_a     (m2_a),
    .in_b     (m2_b),
    .in_side  (sb_r),
    .out_vld  (m2_vld),
    .out_p    (m2_p),
    .out_side (m2_so)
  );

  // stage c: center numerators
  logic                  vc_r;
  s2_t                   sc_r;
  logic signed [NXW-1:0] nx_r, ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r <= m2_so;
      nx_r <= m2_p[0] - m2_p[1];
      ny_r <= m2_p[2] - m2_p[3];
    end
  end

  // third products: squared numerators
  logic signed [NXW-1:0]   m3_a [2];
  logic signed [2*NXW-1:0] m3_p [2];
  s3_t                     m3_si, m3_so;
  logic                    m3_vld;

  assign m3_a  = '{nx_r, ny_r};
  assign m3_si = '{base: sc_r, nx: nx_r, ny: ny_r};

  cf3p_mul #(.LANES(2), .WA(NXW), .WB(NXW), .DG(M3_DG), .WS($bits(s3_t))) u_mul3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vc_r),
    .in_a     (m3_a),
    .in_b     (m3_a),
    .in_side  (m3_si),
    .out_vld  (m3_vld),
    .out_p    (m3_p),
    .out_side (m3_so)
  );

  // stage d: radius numerator squared
  logic           vd_r;
  s3_t            sd_r;
  logic [SQW-1:0] s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= m3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r <= m3_so;
      s_r  <= SQW'(m3_p[0]) + SQW'(m3_p[1]);
    end
  end

  // square root of nx^2 + ny^2
  logic [RTW-1:0] root;
  s3_t            sq_so;
  logic           sq_vld;

  cf3p_sqrt #(.SW(SQW), .WS($bits(s3_t))) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vd_r),
    .in_v     (s_r),
    .in_side  (sd_r),
    .out_vld  (sq_vld),
    .out_root (root),
    .out_side (sq_so)
  );

  // stage e: magnitudes and divider operands
  logic signed [NXW-1:0] nxa, nya;
  logic signed [DDW-1:0] da;
  logic [DDW-2:0]        ad;

  assign nxa = sq_so.nx[NXW-1] ? -sq_so.nx : sq_so.nx;
  assign nya = sq_so.ny[NXW-1] ? -sq_so.ny : sq_so.ny;
  assign da  = sq_so.base.d[DDW-1] ? -sq_so.base.d : sq_so.base.d;
  assign ad  = da[DDW-2:0];

  logic           ve_r;
  s4_t            se_r;
  logic [NMW-1:0] num_r [3];
  logic [DVW-1:0] den_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se_r.x1   <= sq_so.base.x1;
      se_r.y1   <= sq_so.base.y1;
      se_r.code <= sq_so.base.code;
      se_r.negx <= sq_so.nx[NXW-1] ^ sq_so.base.d[DDW-1];
      se_r.negy <= sq_so.ny[NXW-1] ^ sq_so.base.d[DDW-1];
      // rounded center quotients: (2|n| + |d|) / (2|d|)
      num_r[0]  <= NMW'({nxa[NXW-2:0], 1'b0}) + NMW'(ad);
      num_r[1]  <= NMW'({nya[NXW-2:0], 1'b0}) + NMW'(ad);
      den_r[0]  <= DVW'({ad, 1'b0});
      den_r[1]  <= DVW'({ad, 1'b0});
      // radius: floor(root / |d|)
      num_r[2]  <= NMW'(root);
      den_r[2]  <= DVW'(ad);
    end
  end

  logic [NMW-1:0] quo [3];
  s4_t            dv_so;
  logic           dv_vld;

  cf3p_div #(.LANES(3), .NW(NMW), .DW(DVW), .WS($bits(s4_t))) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (ve_r),
    .in_n     (num_r),
    .in_d     (den_r),
    .in_side  (se_r),
    .out_vld  (dv_vld),
    .out_q    (quo),
    .out_side (dv_so)
  );

  // output stage: add offset, saturate, pick status
  localparam logic signed [CSW-1:0] C_MAX = CSW'(CEN_MAX);
  localparam logic signed [CSW-1:0] C_MIN = CSW'(CEN_MIN);
  localparam logic [NMW-1:0]        R_MAX = NMW'(RAD_MAX);

  logic signed [CSW-1:0]   qx, qy, sx, sy;
  logic                    ovx, ovy, ovr;
  logic signed [OUT_W-1:0] cx_sat, cy_sat;
  logic [OUT_W-1:0]        r_sat;

  assign qx  = dv_so.negx ? -CSW'(quo[0]) : CSW'(quo[0]);
  assign qy  = dv_so.negy ? -CSW'(quo[1]) : CSW'(quo[1]);
  assign sx  = CSW'(dv_so.x1) + qx;
  assign sy  = CSW'(dv_so.y1) + qy;
  assign ovx = (sx > C_MAX) || (sx < C_MIN);
  assign ovy = (sy > C_MAX) || (sy < C_MIN);
  assign ovr = quo[2] > R_MAX;

  assign cx_sat = !ovx ? sx[OUT_W-1:0] : (sx[CSW-1] ? C_MIN[OUT_W-1:0] : C_MAX[OUT_W-1:0]);
  assign cy_sat = !ovy ? sy[OUT_W-1:0] : (sy[CSW-1] ? C_MIN[OUT_W-1:0] : C_MAX[OUT_W-1:0]);
  assign r_sat  = ovr ? R_MAX[OUT_W-1:0] : quo[2][OUT_W-1:0];

  logic                    out_vld_r;
  logic signed [OUT_W-1:0] cx_r, cy_r;
  logic [OUT_W-1:0]        rad_r;
  cf3p_status_t            st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_so.code != ST_OK) begin
        cx_r  <= '0;
        cy_r  <= '0;
        rad_r <= '0;
        st_r  <= dv_so.code;
      end else begin
        cx_r  <= cx_sat;
        cy_r  <= cy_sat;
        rad_r <= r_sat;
        st_r  <= (ovx || ovy || ovr) ? ST_OVF : ST_OK;
      end
    end
  end

  assign out_bus.valid      = out_vld_r;
  assign out_bus.center_x   = cx_r;
  assign out_bus.center_y   = cy_r;
  assign out_bus.radius_out = rad_r;
  assign out_bus.fit_status = st_r;

endmodule

`default_nettype wire
